>>> src/binary_boundary_pixel_extract_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the boundary pixel extractor
// Concurrent checks that compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BINARY_BOUNDARY_PIXEL_EXTRACT_ASSERT_SVH
`define BINARY_BOUNDARY_PIXEL_EXTRACT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define BBPE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication.
`define BBPE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BBPE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define BBPE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> src/bbpe_pkg.sv
// ----------------------------------------------------------------------------
// Boundary pixel extractor package
// Field widths, register reset value and the frame phase type.
// ----------------------------------------------------------------------------
package bbpe_pkg;

   localparam int SIDE_W     = 9;
   localparam int SIDE_LIMIT = (2 ** SIDE_W) - 1;
   localparam int ROW_W      = 8;

   localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd256;

   // Phase of the current frame: first row filling, one extra lag item, reporting.
   typedef enum logic [1:0] {
      ST_FILL,
      ST_LAG,
      ST_RUN
   } phase_type;

endpackage

>>> src/bbpe_req_if.sv
// ----------------------------------------------------------------------------
// Pixel input channel
// One pixel beat with its drain marker.
// ----------------------------------------------------------------------------
interface bbpe_req_if;
   logic valid;
   logic ready;
   logic pixel_bit;
   logic drain;

   modport source (output valid, output pixel_bit, output drain, input ready);
   modport sink   (input valid, input pixel_bit, input drain, output ready);
endinterface

>>> src/bbpe_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// One reported position per beat.
// ----------------------------------------------------------------------------
interface bbpe_rsp_if;
   import bbpe_pkg::*;

   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] row_index;
   logic [ROW_W-1:0] col_index;
   logic             is_boundary;
   logic             last_pixel;

   modport source (output valid, output row_index, output col_index,
                   output is_boundary, output last_pixel, input ready);
   modport sink   (input valid, input row_index, input col_index,
                   input is_boundary, input last_pixel, output ready);
endinterface

>>> src/bbpe_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the image side register.
// ----------------------------------------------------------------------------
interface bbpe_csr_if;
   import bbpe_pkg::*;

   logic              valid;
   logic              ready;
   logic [SIDE_W-1:0] side_size;

   modport source (output valid, output side_size, input ready);
   modport sink   (input valid, input side_size, output ready);
endinterface

>>> src/binary_boundary_pixel_extract.sv
// ----------------------------------------------------------------------------
// Binary boundary pixel extractor
// Line stores in one synchronous memory, 3x3 window, raster position counters.
// ----------------------------------------------------------------------------
// Throughput: one pixel beat per cycle while the result register is not stalled,
// set by the single read-modify-write of the line memory per beat. The pixel beat
// that completes a window passes the window stage, then the result register; it
// comes side_size+1 beats after the reported pixel. Reset is synchronous; it clears
// counters, phase and handshake state. The line memory is not cleared, since
// every position that reads a never-written entry lies on the image edge.
// ----------------------------------------------------------------------------
`include "binary_boundary_pixel_extract_assert.svh"

module binary_boundary_pixel_extract #(
   parameter int MAX_SIDE = 256
) (
   input  logic              clock,
   input  logic              reset,
   bbpe_req_if.sink          req_bus,
   bbpe_rsp_if.source        rsp_bus,
   bbpe_csr_if.sink          csr_bus
);
   import bbpe_pkg::*;

   localparam int EFF_MAX = (MAX_SIDE < SIDE_LIMIT) ? MAX_SIDE : SIDE_LIMIT;
   localparam int AW      = $clog2(EFF_MAX);
   localparam int IW      = (AW > ROW_W) ? AW : ROW_W;

   // Effective side minus one, with zero taken as one and saturation at the top.
   function automatic logic [AW-1:0] side_m1_of(input logic [SIDE_W-1:0] v);
      logic [AW-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (int'(v) > EFF_MAX) begin
         r = AW'(EFF_MAX - 1);
      end else begin
         r = AW'(v - 1'b1);
      end
      return r;
   endfunction

   // Entry layout: bit 1 is the pixel one row back, bit 0 two rows back.
   logic [1:0]    line_mem [EFF_MAX];

   logic [AW-1:0] side_m1_ff, side_m1_in;
   phase_type     state_ff, state_in;
   logic [AW-1:0] qc_ff, qc_in;
   logic [AW-1:0] pr_ff, pr_in;
   logic [AW-1:0] pc_ff, pc_in;

   logic          s1_valid_ff, s1_valid_in;
   logic          s1_px_ff;
   logic [AW-1:0] s1_addr_ff;
   logic          s1_emit_ff;
   logic          s1_edge_ff;
   logic          s1_last_ff;
   logic [AW-1:0] s1_row_ff;
   logic [AW-1:0] s1_col_ff;
   logic          s1_fwd_ff;
   logic [1:0]    fwd_data_ff;
   logic [1:0]    rd_data_ff;

   logic [8:0]    win_ff, win_in;

   logic             out_valid_ff, out_valid_in;
   logic [ROW_W-1:0] out_row_ff;
   logic [ROW_W-1:0] out_col_ff;
   logic             out_bnd_ff;
   logic             out_last_ff;

   logic          csr_wr;
   logic          advance;
   logic          req_acc;
   logic          px;
   logic          emit;
   logic          pos_last;
   logic          pos_edge;
   logic          s1_wr;
   logic [1:0]    s1_rd;
   logic [1:0]    wr_data;
   logic [IW-1:0] row_ext;
   logic [IW-1:0] col_ext;

   assign csr_wr        = csr_bus.valid;
   assign csr_bus.ready = 1'b1;

   // The window stage moves whenever the result register is free or draining.
   assign advance       = !s1_valid_ff || !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;
   assign req_acc       = req_bus.valid && advance;
   assign px            = req_bus.pixel_bit && !req_bus.drain;

   assign pos_last = (pr_ff == side_m1_ff) && (pc_ff == side_m1_ff);
   assign pos_edge = (pr_ff == '0) || (pc_ff == '0) ||
                     (pr_ff == side_m1_ff) || (pc_ff == side_m1_ff);

   // Next phase.
   always_comb begin
      state_in = state_ff;
      if (csr_wr) begin
         state_in = ST_FILL;
      end else if (req_acc) begin
         case (state_ff)
            ST_FILL: begin
               if (qc_ff == side_m1_ff) state_in = ST_LAG;
            end
            ST_LAG: begin
               state_in = ST_RUN;
            end
            ST_RUN: begin
               if (pos_last) state_in = ST_FILL;
            end
            default: begin
               state_in = ST_FILL;
            end
         endcase
      end
   end

   // Phase outputs.
   always_comb begin
      case (state_ff)
         ST_RUN:  emit = 1'b1;
         default: emit = 1'b0;
      endcase
   end

   always_comb begin
      side_m1_in = csr_wr ? side_m1_of(csr_bus.side_size) : side_m1_ff;
      qc_in = qc_ff;
      pr_in = pr_ff;
      pc_in = pc_ff;
      if (csr_wr) begin
         qc_in = '0;
         pr_in = '0;
         pc_in = '0;
      end else if (req_acc) begin
         if (emit && pos_last) begin
            qc_in = '0;
            pr_in = '0;
            pc_in = '0;
         end else begin
            qc_in = (qc_ff == side_m1_ff) ? '0 : qc_ff + 1'b1;
            if (emit) begin
               if (pc_ff == side_m1_ff) begin
                  pc_in = '0;
                  pr_in = pr_ff + 1'b1;
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
         end
      end
   end

   // A beat read in the same cycle as the window stage writes its entry
   // takes the written value instead of the stale read.
   assign s1_rd   = s1_fwd_ff ? fwd_data_ff : rd_data_ff;
   assign s1_wr   = s1_valid_ff && advance;
   assign wr_data = {s1_px_ff, s1_rd[1]};
   assign win_in  = {s1_px_ff, s1_rd[1], s1_rd[0], win_ff[8:3]};

   assign s1_valid_in  = advance ? req_acc : s1_valid_ff;
   assign out_valid_in = s1_wr ? s1_emit_ff : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   assign row_ext = IW'(s1_row_ff);
   assign col_ext = IW'(s1_col_ff);

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rd_data_ff  <= line_mem[qc_ff];
         fwd_data_ff <= wr_data;
      end
      if (s1_wr) begin
         line_mem[s1_addr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_m1_ff   <= side_m1_of(SIDE_RESET);
         state_ff     <= ST_FILL;
         qc_ff        <= '0;
         pr_ff        <= '0;
         pc_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         side_m1_ff   <= side_m1_in;
         state_ff     <= state_in;
         qc_ff        <= qc_in;
         pr_ff        <= pr_in;
         pc_ff        <= pc_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_px_ff   <= px;
         s1_addr_ff <= qc_ff;
         s1_emit_ff <= emit;
         s1_edge_ff <= pos_edge;
         s1_last_ff <= pos_last;
         s1_row_ff  <= pr_ff;
         s1_col_ff  <= pc_ff;
         s1_fwd_ff  <= s1_wr && (s1_addr_ff == qc_ff);
      end
      if (s1_wr) begin
         win_ff <= win_in;
      end
      if (s1_wr && s1_emit_ff) begin
         out_row_ff  <= row_ext[ROW_W-1:0];
         out_col_ff  <= col_ext[ROW_W-1:0];
         out_bnd_ff  <= win_in[4] && (s1_edge_ff || (win_in != 9'h1FF));
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.row_index   = out_row_ff;
   assign rsp_bus.col_index   = out_col_ff;
   assign rsp_bus.is_boundary = out_bnd_ff;
   assign rsp_bus.last_pixel  = out_last_ff;

   `BBPE_ASSERT_NOW(a_col_in_range, clock, reset, 1'b1, qc_ff <= side_m1_ff,
                    "input column beyond side")
   `BBPE_ASSERT_NOW(a_pos_in_range, clock, reset, state_ff == ST_RUN,
                    (pr_ff <= side_m1_ff) && (pc_ff <= side_m1_ff),
                    "reported position beyond side")
   `BBPE_ASSERT_NEXT(a_frame_wrap, clock, reset, req_acc && emit && pos_last,
                     (state_ff == ST_FILL) && (qc_ff == '0) && (pr_ff == '0),
                     "frame did not restart after last position")
   `BBPE_ASSERT_NEXT(a_stage_hold, clock, reset, s1_valid_ff && !advance,
                     s1_valid_ff && $stable(s1_addr_ff) && $stable(s1_px_ff),
                     "stalled window stage changed")

endmodule

>>> sim/binary_boundary_pixel_extract_tb.sv
// ----------------------------------------------------------------------------
// Boundary pixel extractor testbench
// Streams binary images of several sides through the block, some frames cut
// short, with random sender bursts and receiver stalls. A scoreboard class
// tracks the line stores and the 3x3 window and checks every result beat.
// ----------------------------------------------------------------------------
module binary_boundary_pixel_extract_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bbpe_pkg::*;

   localparam int          MAX_SIDE    = 256;
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int unsigned RANDOM_BEATS = 780;

   typedef struct packed {
      logic [ROW_W-1:0] row_index;
      logic [ROW_W-1:0] col_index;
      logic             is_boundary;
      logic             last_pixel;
   } pixel_report_type;

   class boundary_tracker_type;
      bit [MAX_SIDE-1:0] upper_line;
      bit [MAX_SIDE-1:0] middle_line;
      bit [8:0]          window_bits;
      bit [16:0]         frame_count;
      bit [SIDE_W-1:0]   side_reg;
      pixel_report_type  pending_reports[$];
      int unsigned       errors;

      function new();
         side_reg = SIDE_RESET;
      endfunction

      function int unsigned side_eff();
         if (side_reg == '0) return 1;
         if (32'(side_reg) > MAX_SIDE) return MAX_SIDE;
         return 32'(side_reg);
      endfunction

      function void set_side(bit [SIDE_W-1:0] value);
         side_reg    = value;
         frame_count = '0;
      endfunction

      function int unsigned pending();
         return pending_reports.size();
      endfunction

      function void note_pixel(bit px_in, bit drain_in);
         int unsigned      s, area, lag, c, qc, p, pr, pc;
         bit               px, on_border, is_last;
         bit [2:0]         newcol;
         pixel_report_type rep;
         s    = side_eff();
         area = s * s;
         lag  = s + 1;
         px   = px_in & ~drain_in;
         c    = 32'(frame_count);
         if (c >= area + lag) c = 0;
         qc = c % s;
         newcol = {px, middle_line[qc], upper_line[qc]};
         upper_line[qc]  = middle_line[qc];
         middle_line[qc] = px;
         window_bits = {newcol, window_bits[8:3]};
         if (c < lag) begin
            frame_count = 17'(c + 1);
            return;
         end
         // The reported pixel sits in the middle of the window.
         p  = c - lag;
         pr = p / s;
         pc = p % s;
         on_border = (pr == 0) || (pc == 0) || (pr == s - 1) || (pc == s - 1);
         is_last   = (p == area - 1);
         rep.row_index   = pr[ROW_W-1:0];
         rep.col_index   = pc[ROW_W-1:0];
         rep.is_boundary = window_bits[4] && (on_border || window_bits != 9'h1FF);
         rep.last_pixel  = is_last;
         pending_reports = {pending_reports, rep};
         frame_count = is_last ? 17'd0 : 17'(c + 1);
      endfunction

      function void check_report(pixel_report_type got);
         pixel_report_type want;
         if (pending_reports.size() == 0) begin
            $display("%0t: result beat with nothing expected: row %0d col %0d", $time,
                     got.row_index, got.col_index);
            errors++;
            return;
         end
         want = pending_reports.pop_front();
         if (got !== want) begin
            errors++;
            if (got.row_index !== want.row_index)
               $display("%0t: row_index expected %0d, actual %0d", $time,
                        want.row_index, got.row_index);
            if (got.col_index !== want.col_index)
               $display("%0t: col_index expected %0d, actual %0d", $time,
                        want.col_index, got.col_index);
            if (got.is_boundary !== want.is_boundary)
               $display("%0t: is_boundary expected %0b, actual %0b (row %0d col %0d)",
                        $time, want.is_boundary, got.is_boundary,
                        want.row_index, want.col_index);
            if (got.last_pixel !== want.last_pixel)
               $display("%0t: last_pixel expected %0b, actual %0b", $time,
                        want.last_pixel, got.last_pixel);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   bbpe_req_if req_bus();
   bbpe_rsp_if rsp_bus();
   bbpe_csr_if csr_bus();

   binary_boundary_pixel_extract dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   boundary_tracker_type tracker = new();
   int unsigned          cycle_count = 0;
   int unsigned          beats_sent  = 0;
   int unsigned          burst_left  = 0;
   int unsigned          stall_left  = 0;
   int unsigned          stall_mode  = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[binary_boundary_pixel_extract] ERROR");
         $finish;
      end
   end

   // Beats are taken from the values present at the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            tracker.check_report({rsp_bus.row_index, rsp_bus.col_index,
                                  rsp_bus.is_boundary, rsp_bus.last_pixel});
         if (req_bus.valid && req_bus.ready)
            tracker.note_pixel(req_bus.pixel_bit, req_bus.drain);
         if (csr_bus.valid && csr_bus.ready)
            tracker.set_side(csr_bus.side_size);
      end
   end

   // Receiver stalls in segments, each with a pattern of its own.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(50, 400);
         end
         stall_left--;
         case (stall_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_bus.ready <= (stall_left % 5 != 0);
            default: rsp_bus.ready <= ($urandom_range(0, 2) == 0);
         endcase
      end
   end

   task automatic send_beat(input bit px, input bit dr);
      int unsigned gap;
      if ($urandom_range(0, 299) == 0) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while (tracker.pending() != 0);
      end else if (burst_left == 0) begin
         gap        = $urandom_range(0, 4);
         burst_left = $urandom_range(1, 48);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_bus.valid     <= 1'b1;
      req_bus.pixel_bit <= px;
      req_bus.drain     <= dr;
      do @(posedge clock); while (!req_bus.ready);
      if (burst_left != 0) burst_left--;
      beats_sent++;
   endtask

   // One frame at the current side; a nonzero cut_at stops it after that many beats.
   task automatic send_frame(input int unsigned set_pct, input int unsigned cut_at);
      int unsigned s, area, total;
      s     = tracker.side_eff();
      area  = s * s;
      total = (cut_at != 0) ? cut_at : area + s + 1;
      for (int unsigned i = 0; i < total; i++) begin
         if (i < area)
            send_beat($urandom_range(0, 99) < set_pct, $urandom_range(0, 99) < 3);
         else
            send_beat($urandom_range(0, 1) != 0, $urandom_range(0, 9) != 0);
      end
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_side(input bit [SIDE_W-1:0] value);
      csr_bus.valid     <= 1'b1;
      csr_bus.side_size <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int unsigned start_beats, pick, side_pick, frames, cut;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.pixel_bit <= 1'b0;
      req_bus.drain     <= 1'b0;
      csr_bus.valid     <= 1'b0;
      csr_bus.side_size <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Side left at its reset value: first row and a bit of the second.
      wait_idle();
      send_frame(90, 300);

      // Side zero acts as a one-pixel image with a two-beat lag.
      wait_idle();
      write_side('0);
      send_beat(1'b1, 1'b0); send_beat(1'b0, 1'b1); send_beat(1'b1, 1'b1);
      send_beat(1'b0, 1'b0); send_beat(1'b1, 1'b0); send_beat(1'b1, 1'b0);
      // Drain inside the image reads as clear even with the pixel bit set.
      send_beat(1'b1, 1'b1); send_beat(1'b1, 1'b0); send_beat(1'b0, 1'b0);
      send_beat(1'b1, 1'b0); send_beat(1'b0, 1'b1); send_beat(1'b0, 1'b1);

      // Oversized side saturates at the line store depth.
      wait_idle();
      write_side({SIDE_W{1'b1}});
      send_frame(60, 300);

      start_beats = beats_sent;
      while (beats_sent - start_beats < RANDOM_BEATS) begin
         pick = $urandom_range(0, 9);
         if (pick < 4)       side_pick = 8;
         else if (pick < 6)  side_pick = 16;
         else if (pick == 6) side_pick = 20;
         else                side_pick = $urandom_range(1, 20);
         wait_idle();
         write_side(side_pick[SIDE_W-1:0]);
         frames = $urandom_range(1, 3);
         for (int unsigned f = 0; f < frames; f++) begin
            if (beats_sent - start_beats >= RANDOM_BEATS) break;
            cut = 0;
            if (f == frames - 1 && $urandom_range(0, 3) == 0)
               cut = $urandom_range(1, side_pick * side_pick + side_pick);
            case ($urandom_range(0, 3))
               0: send_frame(40, cut);
               1: send_frame(75, cut);
               2: send_frame(90, cut);
               default: send_frame(100, cut);
            endcase
         end
      end

      // A last full frame at side eight.
      wait_idle();
      write_side(9'd8);
      send_frame(100, 0);
      wait_idle();

      if (tracker.errors == 0)
         $display("[binary_boundary_pixel_extract] OK");
      else
         $display("[binary_boundary_pixel_extract] ERROR");
      $finish;
   end

endmodule
